// File: src/kntt_pkg.sv
// ----------------------------------------------------------------------------
// kntt_pkg
// Shared types and constants of the forward NTT block: coefficient row
// layout, Montgomery constants, the twiddle table, controller states and
// the command group that the controller sends to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package kntt_pkg;

  // Geometry of the coefficient store: one row holds one transaction.
  localparam int COEFS_PER_ITEM = 4;
  localparam int POLY_LEN       = 256;
  localparam int ROWS           = POLY_LEN / COEFS_PER_ITEM;
  localparam int COEF_W         = 16;
  localparam int ROW_AW         = $clog2(ROWS);
  localparam int ZETA_AW        = 7;
  localparam int LAYER_W        = 3;

  // Last layer (length two): both butterfly operands sit in one row.
  localparam logic [LAYER_W-1:0] LAST_LAYER = 3'd6;
  localparam logic [ROW_AW-1:0]  LAST_ROW   = 6'd63;
  localparam logic [ROW_AW-1:0]  LAST_PAIR  = 6'd31;

  // Montgomery reduction constants.
  localparam logic [COEF_W-1:0]  QINV    = 16'd62209;
  localparam logic signed [31:0] FIELD_Q = 32'sd3329;

  typedef logic [COEFS_PER_ITEM-1:0][COEF_W-1:0] row_t;

  // Twiddle factors in Montgomery form, taken in order from entry 1.
  localparam logic signed [COEF_W-1:0] ZETA [128] = '{
    -16'sd1044, -16'sd758,  -16'sd359,  -16'sd1517, 16'sd1493,  16'sd1422,
    16'sd287,   16'sd202,   -16'sd171,  16'sd622,   16'sd1577,  16'sd182,
    16'sd962,   -16'sd1202, -16'sd1474, 16'sd1468,  16'sd573,   -16'sd1325,
    16'sd264,   16'sd383,   -16'sd829,  16'sd1458,  -16'sd1602, -16'sd130,
    -16'sd681,  16'sd1017,  16'sd732,   16'sd608,   -16'sd1542, 16'sd411,
    -16'sd205,  -16'sd1571, 16'sd1223,  16'sd652,   -16'sd552,  16'sd1015,
    -16'sd1293, 16'sd1491,  -16'sd282,  -16'sd1544, 16'sd516,   -16'sd8,
    -16'sd320,  -16'sd666,  -16'sd1618, -16'sd1162, 16'sd126,   16'sd1469,
    -16'sd853,  -16'sd90,   -16'sd271,  16'sd830,   16'sd107,   -16'sd1421,
    -16'sd247,  -16'sd951,  -16'sd398,  16'sd961,   -16'sd1508, -16'sd725,
    16'sd448,   -16'sd1065, 16'sd677,   -16'sd1275, -16'sd1103, 16'sd430,
    16'sd555,   16'sd843,   -16'sd1251, 16'sd871,   16'sd1550,  16'sd105,
    16'sd422,   16'sd587,   16'sd177,   -16'sd235,  -16'sd291,  -16'sd460,
    16'sd1574,  16'sd1653,  -16'sd246,  16'sd778,   16'sd1159,  -16'sd147,
    -16'sd777,  16'sd1483,  -16'sd602,  16'sd1119,  -16'sd1590, 16'sd644,
    -16'sd872,  16'sd349,   16'sd418,   16'sd329,   -16'sd156,  -16'sd75,
    16'sd817,   16'sd1097,  16'sd603,   16'sd610,   16'sd1322,  -16'sd1285,
    -16'sd1465, 16'sd384,   -16'sd1215, -16'sd136,  16'sd1218,  -16'sd1335,
    -16'sd874,  16'sd220,   -16'sd1187, -16'sd1659, -16'sd1185, -16'sd1530,
    -16'sd1278, 16'sd794,   -16'sd1510, -16'sd854,  -16'sd870,  16'sd478,
    -16'sd108,  -16'sd308,  16'sd996,   16'sd991,   16'sd958,   -16'sd1460,
    16'sd1522,  16'sd1628
  };

  // Controller states.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_MUL,
    ST_RED,
    ST_SHIFT,
    ST_WRITE_A,
    ST_WRITE_B,
    ST_EMIT
  } kntt_state_t;

  // Source of the row written into the store.
  typedef enum logic [1:0] {
    WR_INPUT,
    WR_SUM,
    WR_DIFF,
    WR_SPLIT
  } wr_src_t;

  // Command group from controller to datapath.
  typedef struct packed {
    logic                wr_en;
    wr_src_t             wr_src;
    logic [ROW_AW-1:0]   wr_row;
    logic                rd_en;
    logic [ROW_AW-1:0]   rd_row_a;
    logic [ROW_AW-1:0]   rd_row_b;
    logic [ZETA_AW-1:0]  zeta_idx;
    logic                pair_mode;
    logic                emit;
    logic                emit_last;
  } kntt_cmd_t;

endpackage

`default_nettype wire

// File: src/kntt_mont_lane.sv
// ----------------------------------------------------------------------------
// kntt_mont_lane
// One Montgomery multiplier lane: product, low-half reduction factor and
// exact shift, one register after each step.
// ----------------------------------------------------------------------------
`default_nettype none

module kntt_mont_lane
  import kntt_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic signed [COEF_W-1:0] zeta,
  input  wire logic signed [COEF_W-1:0] x,
  output logic signed [COEF_W-1:0]      t
);

  logic signed [31:0]       prod;
  logic signed [COEF_W-1:0] ufac;
  logic signed [31:0]       diff;

  // Full product of the twiddle and the operand.
  always_ff @(posedge clk) begin
    prod <= zeta * x;
  end

  // Reduction factor: low half of the product times the inverse of q.
  always_ff @(posedge clk) begin
    ufac <= COEF_W'(prod[COEF_W-1:0] * QINV);
  end

  // The difference is a multiple of 2^16, so its upper half is the result.
  always_comb begin
    diff = prod - 32'(ufac * FIELD_Q);
  end

  always_ff @(posedge clk) begin
    t <= diff[31:COEF_W];
  end

endmodule

`default_nettype wire

// File: src/kntt_datapath.sv
// ----------------------------------------------------------------------------
// kntt_datapath
// Coefficient store of 64 rows of four coefficients, two registered read
// ports, four Montgomery lanes with their sums and differences, and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module kntt_datapath
  import kntt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire kntt_cmd_t         cmd,
  input  wire row_t              in_row,
  output row_t                   out_row,
  output logic                   out_strobe,
  output logic                   out_last
);

  row_t                     mem [ROWS];
  row_t                     rd_a;
  row_t                     rd_b;
  row_t                     wr_data;
  logic signed [COEF_W-1:0] zeta_reg;
  logic signed [COEF_W-1:0] hi   [COEFS_PER_ITEM];
  logic signed [COEF_W-1:0] lo   [COEFS_PER_ITEM];
  logic signed [COEF_W-1:0] t    [COEFS_PER_ITEM];
  logic [COEF_W-1:0]        sum  [COEFS_PER_ITEM];
  logic [COEF_W-1:0]        dif  [COEFS_PER_ITEM];

  // Store: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_row] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_a     <= mem[cmd.rd_row_a];
      rd_b     <= mem[cmd.rd_row_b];
      zeta_reg <= ZETA[cmd.zeta_idx];
    end
  end

  // Operand selection: in the last layer both halves come from one row.
  for (genvar i = 0; i < COEFS_PER_ITEM; i++) begin : g_lane
    always_comb begin
      if (cmd.pair_mode) begin
        lo[i] = rd_a[i % 2];
        hi[i] = rd_a[(i % 2) + 2];
      end else begin
        lo[i] = rd_a[i];
        hi[i] = rd_b[i];
      end
      sum[i] = lo[i] + t[i];
      dif[i] = lo[i] - t[i];
    end

    kntt_mont_lane u_lane (
      .clk  (clk),
      .zeta (zeta_reg),
      .x    (hi[i]),
      .t    (t[i])
    );
  end

  // Write data selection.
  always_comb begin
    unique case (cmd.wr_src)
      WR_INPUT: wr_data = in_row;
      WR_SUM:   wr_data = {sum[3], sum[2], sum[1], sum[0]};
      WR_DIFF:  wr_data = {dif[3], dif[2], dif[1], dif[0]};
      WR_SPLIT: wr_data = {dif[1], dif[0], sum[1], sum[0]};
      default:  wr_data = in_row;
    endcase
  end

  // Result strobe and read data both appear in the cycle after the emit read.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_strobe <= 1'b0;
      out_last   <= 1'b0;
    end else begin
      out_strobe <= cmd.emit;
      out_last   <= cmd.emit_last;
    end
  end

  assign out_row = rd_a;

endmodule

`default_nettype wire

// File: src/kntt_ctrl.sv
// ----------------------------------------------------------------------------
// kntt_ctrl
// Sequencer of the transform: counts loaded transactions, walks the seven
// butterfly layers row pair by row pair, then reads the store out in order.
// ----------------------------------------------------------------------------
`default_nettype none

module kntt_ctrl
  import kntt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  output kntt_cmd_t     cmd
);

  kntt_state_t          state;
  kntt_state_t          state_next;
  logic [ROW_AW-1:0]    load_count;
  logic [LAYER_W-1:0]   layer;
  logic [ROW_AW-1:0]    idx;
  logic [ROW_AW-1:0]    span;
  logic [ROW_AW-1:0]    mask;
  logic [ROW_AW-1:0]    row_a;
  logic [ROW_AW-1:0]    row_b;
  logic [ZETA_AW-1:0]   zeta_idx;
  logic                 pair_mode;
  logic                 pair_last;
  logic                 accept;

  assign accept    = start && (state == ST_LOAD);
  assign pair_mode = (layer == LAST_LAYER);
  assign pair_last = pair_mode ? (idx == LAST_ROW) : (idx == LAST_PAIR);

  // Row addresses and twiddle index of the current butterfly pair.
  always_comb begin
    span = ROW_AW'(6'd32 >> layer);
    mask = span - 6'd1;
    if (pair_mode) begin
      row_a    = idx;
      row_b    = idx;
      zeta_idx = {1'b1, idx};
    end else begin
      row_a    = ((idx & ~mask) << 1) | (idx & mask);
      row_b    = row_a | span;
      zeta_idx = (ZETA_AW'(1) << layer) | ZETA_AW'(idx[4:0] >> (3'd5 - layer));
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:    if (accept && load_count == LAST_ROW) state_next = ST_READ;
      ST_READ:    state_next = ST_MUL;
      ST_MUL:     state_next = ST_RED;
      ST_RED:     state_next = ST_SHIFT;
      ST_SHIFT:   state_next = ST_WRITE_A;
      ST_WRITE_A: begin
        if (!pair_mode) begin
          state_next = ST_WRITE_B;
        end else if (pair_last) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_WRITE_B: state_next = ST_READ;
      ST_EMIT:    if (idx == LAST_ROW) state_next = ST_LOAD;
      default:    state_next = ST_LOAD;
    endcase
  end

  // Outputs: commands to the datapath.
  always_comb begin
    cmd           = '0;
    cmd.wr_src    = WR_INPUT;
    cmd.rd_row_a  = row_a;
    cmd.rd_row_b  = row_b;
    cmd.zeta_idx  = zeta_idx;
    cmd.pair_mode = pair_mode;
    cmd.wr_row    = row_a;
    busy          = (state != ST_LOAD);
    unique case (state)
      ST_LOAD: begin
        cmd.wr_en  = accept;
        cmd.wr_row = load_count;
      end
      ST_READ: cmd.rd_en = 1'b1;
      ST_WRITE_A: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = pair_mode ? WR_SPLIT : WR_SUM;
      end
      ST_WRITE_B: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = WR_DIFF;
        cmd.wr_row = row_b;
      end
      ST_EMIT: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_row_a  = idx;
        cmd.emit      = 1'b1;
        cmd.emit_last = (idx == LAST_ROW);
      end
      default: ;
    endcase
  end

  // State and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_count <= '0;
      layer      <= '0;
      idx        <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        load_count <= load_count + 6'd1;
        layer      <= '0;
        idx        <= '0;
      end
      // A pair is finished after its last write.
      if ((state == ST_WRITE_B) || (state == ST_WRITE_A && pair_mode)) begin
        if (pair_last) begin
          idx <= '0;
          if (!pair_mode) begin
            layer <= layer + 3'd1;
          end
        end else begin
          idx <= idx + 6'd1;
        end
      end
      if (state == ST_EMIT) begin
        idx <= idx + 6'd1;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/kyber_forward_ntt.sv
// ----------------------------------------------------------------------------
// kyber_forward_ntt
// Forward NTT of one 256-coefficient polynomial over q = 3329 with
// Montgomery butterflies; loads 64 transactions, transforms, emits 64.
// ----------------------------------------------------------------------------
// Order: 64 loads, then six layers of 32 row pairs (read, multiply, reduce,
// shift, write A, write B), then 64 single-row pairs (read, multiply, reduce,
// shift, split write), then 64 reads. A new polynomial is taken only after
// the last read-out.
// Reset: synchronous; clears the load count, the sequencer and the result flags, not the store.
// The receiver cannot stall; busy is low while transactions are taken.
// ----------------------------------------------------------------------------
`default_nettype none

module kyber_forward_ntt
  import kntt_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic signed [COEF_W-1:0] coef_a,
  input  wire logic signed [COEF_W-1:0] coef_b,
  input  wire logic signed [COEF_W-1:0] coef_c,
  input  wire logic signed [COEF_W-1:0] coef_d,
  output logic                          result_strobe,
  output logic signed [COEF_W-1:0]      out_a,
  output logic signed [COEF_W-1:0]      out_b,
  output logic signed [COEF_W-1:0]      out_c,
  output logic signed [COEF_W-1:0]      out_d,
  output logic                          final_group
);

  kntt_cmd_t cmd;
  row_t      in_row;
  row_t      out_row;

  assign in_row = {coef_d, coef_c, coef_b, coef_a};

  kntt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  kntt_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_row     (in_row),
    .out_row    (out_row),
    .out_strobe (result_strobe),
    .out_last   (final_group)
  );

  assign out_a = out_row[0];
  assign out_b = out_row[1];
  assign out_c = out_row[2];
  assign out_d = out_row[3];

  // A result only follows a read-out cycle of the sequencer.
  a_strobe_after_emit: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(busy) && $past(cmd.emit))
    else $error("result strobe without a preceding read-out");

  // The last-group flag never stands alone.
  a_last_with_strobe: assert property (@(posedge clk) disable iff (rst)
    final_group |-> result_strobe)
    else $error("final_group without result strobe");

  // An accepted transaction is written into the store in the same cycle.
  a_accept_writes: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> (cmd.wr_en && cmd.wr_src == WR_INPUT))
    else $error("accepted transaction not written to the store");

  // The transform only starts on an accepted transaction.
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start");

endmodule

`default_nettype wire
